// File: rtl/set_assoc_cache_fifo_defines.svh
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_defines
// Assertion macros used by the cache top level.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_FIFO_DEFINES_SVH
`define SET_ASSOC_CACHE_FIFO_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SACF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cache assertion failed");

// antecedent implies consequent in the next cycle
`define SACF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cache assertion failed");

`endif

// File: rtl/sacf_pkg.sv
// ----------------------------------------------------------------------------
// sacf_pkg
// Sizes, request codes and controller/datapath handshake types of the cache.
// ----------------------------------------------------------------------------
package sacf_pkg;

    localparam int MEM_WORDS  = 512;
    localparam int LINE_WORDS = 8;
    localparam int NUM_WAYS   = 4;
    localparam int NUM_SETS   = 4;

    localparam int ADDR_W  = $clog2(MEM_WORDS);
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 32;
    localparam int OFF_W   = $clog2(LINE_WORDS);
    localparam int SET_W   = $clog2(NUM_SETS);
    localparam int WAY_W   = $clog2(NUM_WAYS);
    localparam int TAG_W   = ADDR_W - OFF_W - SET_W;
    localparam int BLK_W   = ADDR_W - OFF_W;
    localparam int LINE_AW = SET_W + WAY_W + OFF_W;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic mem_wr;
        logic fill;
        logic line_rd;
        logic line_wr;
        logic clear;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic req_valid;
        logic clear_last;
        logic lkp_hit;
        logic hit;
        logic is_write;
        logic fill_done;
        logic out_full;
    } t_sts;

endpackage

// File: rtl/sacf_if.sv
// ----------------------------------------------------------------------------
// sacf_if
// Request and response channels of the cache.
// ----------------------------------------------------------------------------
interface sacf_req_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic [sacf_pkg::ADDR_W-1:0]         address;
    logic signed [sacf_pkg::DATA_W-1:0]  write_data;

    modport source (output valid, output req_type, output address, output write_data,
                    input ready);
    modport sink   (input valid, input req_type, input address, input write_data,
                    output ready);
endinterface

interface sacf_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [sacf_pkg::DATA_W-1:0]  read_data;
    logic                                hit;
    logic [sacf_pkg::WAY_W-1:0]          way_used;
    logic [sacf_pkg::CNT_W-1:0]          hit_total;
    logic [sacf_pkg::CNT_W-1:0]          miss_total;

    modport source (output valid, output read_data, output hit, output way_used,
                    output hit_total, output miss_total, input ready);
    modport sink   (input valid, input read_data, input hit, input way_used,
                    input hit_total, input miss_total, output ready);
endinterface

// File: rtl/set_assoc_cache_fifo.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo
// Four-way set-associative write-through cache with FIFO replacement in
// front of a 512-word backing memory.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  i_req   | in        | req_type, address, write_data
//  o_rsp   | out       | read_data, hit, way_used, hit_total, miss_total
//
//  The cost of a read or write miss is the eight-word line fill through
//  the single port of the backing memory.
//  After reset the backing memory is loaded with its own addresses, one word
//  a cycle, and i_req.ready stays low until the last word is written.
//  A result waits in the output register; the next request is taken meanwhile.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_fifo_defines.svh"

module set_assoc_cache_fifo (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sacf_req_if.sink   i_req,
    sacf_rsp_if.source o_rsp
);
    import sacf_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    sacf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    sacf_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

    `SACF_ASSERT_SAME(a_mem_port_free, i_clk, i_rst_n, w_cmd.mem_wr, !w_cmd.fill && !w_cmd.clear)
    `SACF_ASSERT_SAME(a_no_req_in_clear, i_clk, i_rst_n, w_cmd.clear, !i_req.ready)
    `SACF_ASSERT_SAME(a_load_when_free, i_clk, i_rst_n, w_cmd.finish, !w_sts.out_full)
    `SACF_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, w_cmd.finish, o_rsp.valid)

endmodule

// File: rtl/sacf_ctrl.sv
// ----------------------------------------------------------------------------
// sacf_ctrl
// Sequencer of the cache: memory init, lookup, write-through, line fill,
// line access and result hand-off.
// ----------------------------------------------------------------------------
module sacf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sacf_pkg::t_sts i_sts,
    output sacf_pkg::t_cmd o_cmd
);
    import sacf_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_LOOKUP = 8'b0000_0100,
        S_MEMWR  = 8'b0000_1000,
        S_FILL   = 8'b0001_0000,
        S_LWRITE = 8'b0010_0000,
        S_LREAD  = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.accept = 1'b1;
                if (i_sts.req_valid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                if (i_sts.is_write) begin
                    n_state = S_MEMWR;
                end else if (i_sts.lkp_hit) begin
                    n_state = S_LREAD;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_MEMWR: begin
                o_cmd.mem_wr = 1'b1;
                n_state = i_sts.hit ? S_LWRITE : S_FILL;
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.fill_done) begin
                    n_state = i_sts.is_write ? S_RESP : S_LREAD;
                end
            end
            S_LWRITE: begin
                o_cmd.line_wr = 1'b1;
                n_state = S_RESP;
            end
            S_LREAD: begin
                o_cmd.line_rd = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!i_sts.out_full) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// File: rtl/sacf_dp.sv
// ----------------------------------------------------------------------------
// sacf_dp
// Datapath of the cache: request register, tag store, fill pointers,
// backing memory, line memory, counters and result register.
// ----------------------------------------------------------------------------
module sacf_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sacf_pkg::t_cmd i_cmd,
    output sacf_pkg::t_sts o_sts,
    sacf_req_if.sink       i_req,
    sacf_rsp_if.source     o_rsp
);
    import sacf_pkg::*;

    logic                     r_type;
    logic [ADDR_W-1:0]        r_addr;
    logic signed [DATA_W-1:0] r_wdata;

    logic                     r_valid [NUM_SETS][NUM_WAYS];
    logic [TAG_W-1:0]         r_tag   [NUM_SETS][NUM_WAYS];
    logic [WAY_W-1:0]         r_fptr  [NUM_SETS];

    logic                     r_hit;
    logic [WAY_W-1:0]         r_way;

    logic [DATA_W-1:0]        r_mem [MEM_WORDS];
    logic [DATA_W-1:0]        r_mem_q;
    logic [ADDR_W-1:0]        r_clr_cnt;

    logic [DATA_W-1:0]        r_line [2**LINE_AW];
    logic [DATA_W-1:0]        r_line_q;

    logic [OFF_W:0]           r_fill_cnt;
    logic                     r_wr_vld;
    logic [OFF_W-1:0]         r_wr_off;

    logic [CNT_W-1:0]         r_hit_cnt;
    logic [CNT_W-1:0]         r_miss_cnt;
    logic [CNT_W-1:0]         n_hit_cnt;
    logic [CNT_W-1:0]         n_miss_cnt;

    logic                     r_out_vld;
    logic signed [DATA_W-1:0] r_out_data;
    logic                     r_out_hit;
    logic [WAY_W-1:0]         r_out_way;

    logic [OFF_W-1:0]         w_off;
    logic [SET_W-1:0]         w_set;
    logic [TAG_W-1:0]         w_tag;
    logic [BLK_W-1:0]         w_blk;
    logic                     w_hit;
    logic [WAY_W-1:0]         w_hit_way;
    logic [WAY_W-1:0]         w_vic;
    logic                     w_fill_rd;
    logic                     w_mem_we;
    logic [ADDR_W-1:0]        w_mem_a;
    logic [DATA_W-1:0]        w_mem_wd;
    logic                     w_line_we;
    logic [LINE_AW-1:0]       w_line_a;
    logic [DATA_W-1:0]        w_line_wd;
    logic                     w_is_write;

    assign w_off      = r_addr[OFF_W-1:0];
    assign w_set      = r_addr[OFF_W +: SET_W];
    assign w_tag      = r_addr[ADDR_W-1 -: TAG_W];
    assign w_blk      = r_addr[ADDR_W-1:OFF_W];
    assign w_is_write = (r_type == REQ_WRITE);

    assign i_req.ready = i_cmd.accept;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_req.valid) begin
            r_type  <= i_req.req_type;
            r_addr  <= i_req.address;
            r_wdata <= i_req.write_data;
        end
    end

    always_comb begin
        w_hit     = 1'b0;
        w_hit_way = '0;
        w_vic     = r_fptr[w_set];
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (r_valid[w_set][w] && (r_tag[w_set][w] == w_tag)) begin
                w_hit     = 1'b1;
                w_hit_way = WAY_W'(w);
            end
            if (!r_valid[w_set][w]) begin
                w_vic = WAY_W'(w);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SETS; s++) begin
                r_fptr[s] <= '0;
                for (int w = 0; w < NUM_WAYS; w++) begin
                    r_valid[s][w] <= 1'b0;
                end
            end
        end else if (i_cmd.lookup && !w_hit) begin
            r_valid[w_set][w_vic] <= 1'b1;
            r_fptr[w_set]         <= w_vic + WAY_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_hit <= w_hit;
            r_way <= w_hit ? w_hit_way : w_vic;
            if (!w_hit) begin
                r_tag[w_set][w_vic] <= w_tag;
            end
        end
    end

    assign w_fill_rd = i_cmd.fill && !r_fill_cnt[OFF_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_cnt <= '0;
            r_wr_vld   <= 1'b0;
            r_clr_cnt  <= '0;
        end else begin
            r_wr_vld <= w_fill_rd;
            if (i_cmd.lookup) begin
                r_fill_cnt <= '0;
            end else if (w_fill_rd) begin
                r_fill_cnt <= r_fill_cnt + (OFF_W+1)'(1);
            end
            if (i_cmd.clear) begin
                r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fill_rd) begin
            r_wr_off <= r_fill_cnt[OFF_W-1:0];
        end
    end

    assign w_mem_we = i_cmd.clear || i_cmd.mem_wr;
    assign w_mem_wd = i_cmd.clear ? DATA_W'(r_clr_cnt) : r_wdata;

    always_comb begin
        priority if (i_cmd.clear) begin
            w_mem_a = r_clr_cnt;
        end else if (i_cmd.mem_wr) begin
            w_mem_a = r_addr;
        end else begin
            w_mem_a = {w_blk, r_fill_cnt[OFF_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_a] <= w_mem_wd;
        end
        if (w_fill_rd) begin
            r_mem_q <= r_mem[w_mem_a];
        end
    end

    assign w_line_we = r_wr_vld || i_cmd.line_wr;
    assign w_line_wd = r_wr_vld ? r_mem_q : r_wdata;
    assign w_line_a  = r_wr_vld ? {w_set, r_way, r_wr_off} : {w_set, r_way, w_off};

    always_ff @(posedge i_clk) begin
        if (w_line_we) begin
            r_line[w_line_a] <= w_line_wd;
        end
        if (i_cmd.line_rd) begin
            r_line_q <= r_line[w_line_a];
        end
    end

    assign n_hit_cnt  = r_hit_cnt + CNT_W'(!w_is_write && r_hit);
    assign n_miss_cnt = r_miss_cnt + CNT_W'(!r_hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_hit_cnt  <= n_hit_cnt;
                r_miss_cnt <= n_miss_cnt;
                r_out_vld  <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_data <= w_is_write ? r_wdata : r_line_q;
            r_out_hit  <= r_hit;
            r_out_way  <= r_way;
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.read_data  = r_out_data;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.way_used   = r_out_way;
    assign o_rsp.hit_total  = r_hit_cnt;
    assign o_rsp.miss_total = r_miss_cnt;

    assign o_sts.req_valid  = i_req.valid;
    assign o_sts.clear_last = &r_clr_cnt;
    assign o_sts.lkp_hit    = w_hit;
    assign o_sts.hit        = r_hit;
    assign o_sts.is_write   = w_is_write;
    assign o_sts.fill_done  = r_wr_vld && (r_wr_off == OFF_W'(LINE_WORDS - 1));
    assign o_sts.out_full   = r_out_vld && !o_rsp.ready;

endmodule

// File: tb/tb_set_assoc_cache_fifo.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_fifo
// Self-checking bench for the four-way write-through cache. A mirror of the
// backing memory, tags, line data, fill pointers and counters predicts every
// response. Requests and responses stall at random. Directed traffic covers
// cold misses, hits, write misses and FIFO eviction. Random traffic, set
// thrashing, a long response hold-off and a drain pause follow.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_fifo;
    import sacf_pkg::*;

    localparam int RESET_CYCLES    = 7;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int RSP_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES     = 40;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [DATA_W-1:0] t_word;

    typedef struct {
        t_word            read_data;
        logic             hit;
        logic [WAY_W-1:0] way_used;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
    } t_cache_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sacf_req_if req_if ();
    sacf_rsp_if rsp_if ();

    set_assoc_cache_fifo u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // cache mirror
    t_word            mem_mirror [MEM_WORDS];
    logic             way_valid  [NUM_SETS][NUM_WAYS];
    logic [TAG_W-1:0] way_tag    [NUM_SETS][NUM_WAYS];
    t_word            way_words  [NUM_SETS][NUM_WAYS][LINE_WORDS];
    logic [WAY_W-1:0] oldest_way [NUM_SETS];
    logic [CNT_W-1:0] hits_seen   = '0;
    logic [CNT_W-1:0] misses_seen = '0;

    t_cache_result    pending_results [$];
    t_cache_result    want;
    int unsigned      fail_count     = 0;
    int unsigned      idle_cycles    = 0;
    int unsigned      quiet_items    = 0;
    int unsigned      rsp_stall_left = 0;
    int unsigned      rsp_quiet_left = 0;
    int unsigned      rsp_pick;
    int unsigned      hold_rsp_req   = 0;
    int unsigned      hold_rsp_done  = 0;
    logic [SET_W-1:0] hot_set        = '0;
    logic [TAG_W-1:0] hot_base       = '0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [WAY_W-1:0] fill_way(logic [SET_W-1:0] set_idx,
                                                  logic [TAG_W-1:0] tag,
                                                  logic [BLK_W-1:0] blk);
        logic [WAY_W-1:0] victim;
        bit               found_free;
        victim     = oldest_way[set_idx];
        found_free = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!found_free && !way_valid[set_idx][w]) begin
                victim     = WAY_W'(w);
                found_free = 1'b1;
            end
        end
        way_valid[set_idx][victim] = 1'b1;
        way_tag[set_idx][victim]   = tag;
        for (int i = 0; i < LINE_WORDS; i++)
            way_words[set_idx][victim][i] = mem_mirror[{blk, OFF_W'(i)}];
        oldest_way[set_idx] = WAY_W'((victim + 1) % NUM_WAYS);
        return victim;
    endfunction

    function automatic t_cache_result cache_access(logic req_type, t_addr addr, t_word wdata);
        logic [BLK_W-1:0] blk;
        logic [OFF_W-1:0] off;
        logic [SET_W-1:0] set_idx;
        logic [TAG_W-1:0] tag;
        logic [WAY_W-1:0] way;
        logic             present;
        t_cache_result    res;
        blk     = addr[ADDR_W-1:OFF_W];
        off     = addr[OFF_W-1:0];
        set_idx = blk[SET_W-1:0];
        tag     = blk[BLK_W-1:SET_W];
        way     = '0;
        present = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!present && way_valid[set_idx][w] && way_tag[set_idx][w] == tag) begin
                way     = WAY_W'(w);
                present = 1'b1;
            end
        end
        if (req_type == REQ_WRITE) begin
            mem_mirror[addr] = wdata;
            if (!present) begin
                misses_seen = misses_seen + 1'b1;
                way         = fill_way(set_idx, tag, blk);
            end
            way_words[set_idx][way][off] = wdata;
        end else if (present) begin
            hits_seen = hits_seen + 1'b1;
        end else begin
            misses_seen = misses_seen + 1'b1;
            way         = fill_way(set_idx, tag, blk);
        end
        res.read_data  = way_words[set_idx][way][off];
        res.hit        = present;
        res.way_used   = way;
        res.hit_total  = hits_seen;
        res.miss_total = misses_seen;
        return res;
    endfunction

    function automatic int unsigned draw_gap();
        int unsigned r;
        if (quiet_items > 0) begin
            quiet_items--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            quiet_items = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_addr line_addr(logic [SET_W-1:0] set_idx, logic [TAG_W-1:0] tag);
        return {tag, set_idx, OFF_W'($urandom)};
    endfunction

    // mostly a small working set that drifts, the rest anywhere in memory
    function automatic t_addr draw_addr();
        if ($urandom_range(0, 99) < 3) begin
            hot_set  = SET_W'($urandom);
            hot_base = TAG_W'($urandom);
        end
        if ($urandom_range(0, 99) < 70)
            return line_addr(hot_set, TAG_W'(hot_base + $urandom_range(0, 5)));
        return t_addr'($urandom);
    endfunction

    function automatic void compare_field(string name, logic [31:0] exp_val, logic [31:0] got);
        if (got !== exp_val) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, exp_val, got);
            fail_count++;
        end
    endfunction

    task automatic send_req(input logic req_type, input t_addr addr, input t_word wdata);
        int unsigned gap;
        req_if.valid      <= 1'b1;
        req_if.req_type   <= req_type;
        req_if.address    <= addr;
        req_if.write_data <= wdata;
        do @(posedge i_clk); while (!req_if.ready);
        pending_results.push_back(cache_access(req_type, addr, wdata));
        gap = draw_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_basic_access();
        send_req(REQ_READ,  t_addr'(0),   '0);
        send_req(REQ_READ,  t_addr'(7),   32'hFFFF_FFFF);
        send_req(REQ_READ,  t_addr'(511), '0);
        send_req(REQ_WRITE, t_addr'(511), 32'h7FFF_FFFF);
        send_req(REQ_WRITE, t_addr'(256), 32'h8000_0000);
        send_req(REQ_READ,  t_addr'(256), '0);
        send_req(REQ_WRITE, t_addr'(3),   32'h0000_0000);
        send_req(REQ_WRITE, t_addr'(5),   32'hFFFF_FFFF);
        send_req(REQ_READ,  t_addr'(5),   '0);
        send_req(REQ_WRITE, t_addr'(255), 32'h5555_5555);
        send_req(REQ_WRITE, t_addr'(254), 32'hAAAA_AAAA);
    endtask

    // fill set 0, evict in fill order, refetch a line written through
    task automatic test_fifo_replacement();
        send_req(REQ_READ,  t_addr'(64),  '0);
        send_req(REQ_READ,  t_addr'(96),  '0);
        send_req(REQ_READ,  t_addr'(128), '0);
        send_req(REQ_READ,  t_addr'(0),   '0);
        send_req(REQ_READ,  t_addr'(257), '0);
        send_req(REQ_READ,  t_addr'(256), '0);
        send_req(REQ_READ,  t_addr'(5),   '0);
        send_req(REQ_WRITE, t_addr'(448), 32'h1234_5678);
        send_req(REQ_READ,  t_addr'(96),  '0);
        send_req(REQ_READ,  t_addr'(511), '0);
    endtask

    task automatic test_random_traffic(int unsigned n_items);
        repeat (n_items) send_req(1'($urandom), draw_addr(), $urandom);
    endtask

    task automatic test_set_thrash(int unsigned n_items);
        logic [SET_W-1:0] set_idx;
        logic [TAG_W-1:0] base;
        int unsigned      n_tags;
        set_idx = '0;
        base    = '0;
        n_tags  = 5;
        for (int k = 0; k < n_items; k++) begin
            if (k % 30 == 0) begin
                set_idx = SET_W'($urandom);
                base    = TAG_W'($urandom);
                n_tags  = $urandom_range(5, 8);
            end
            send_req(1'($urandom),
                     line_addr(set_idx, TAG_W'(base + $urandom_range(0, n_tags - 1))),
                     $urandom);
        end
    endtask

    task automatic test_output_backpressure();
        hold_rsp_req++;
        repeat (40) send_req(1'($urandom), draw_addr(), $urandom);
    endtask

    task automatic test_sender_pause();
        repeat (20) send_req(1'($urandom), draw_addr(), $urandom);
        drain_results();
        repeat (20) send_req(1'($urandom), draw_addr(), $urandom);
    endtask

    // check each response transfer, drive response ready
    always @(posedge i_clk) begin
        if (rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected response: read_data 0x%08h", rsp_if.read_data);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("read_data",  want.read_data,       rsp_if.read_data);
                compare_field("hit",        32'(want.hit),        32'(rsp_if.hit));
                compare_field("way_used",   32'(want.way_used),   32'(rsp_if.way_used));
                compare_field("hit_total",  want.hit_total,       rsp_if.hit_total);
                compare_field("miss_total", want.miss_total,      rsp_if.miss_total);
            end
        end
        if (hold_rsp_req != hold_rsp_done) begin
            hold_rsp_done  = hold_rsp_req;
            rsp_stall_left = RSP_HOLD_CYCLES;
        end else if (rsp_stall_left == 0 && rsp_quiet_left > 0) begin
            rsp_quiet_left--;
        end else if (rsp_stall_left == 0) begin
            rsp_pick = $urandom_range(0, 99);
            if (rsp_pick < 2)
                rsp_quiet_left = $urandom_range(40, 120);
            else if (rsp_pick < 14)
                rsp_stall_left = $urandom_range(1, 3);
            else if (rsp_pick < 17)
                rsp_stall_left = $urandom_range(8, 30);
        end
        if (rsp_stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall_left--;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("set_assoc_cache_fifo: mismatch");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.req_type   <= REQ_READ;
        req_if.address    <= '0;
        req_if.write_data <= '0;
        for (int i = 0; i < MEM_WORDS; i++)
            mem_mirror[i] = t_word'(i);
        for (int s = 0; s < NUM_SETS; s++) begin
            oldest_way[s] = '0;
            for (int w = 0; w < NUM_WAYS; w++) begin
                way_valid[s][w] = 1'b0;
                way_tag[s][w]   = '0;
                for (int i = 0; i < LINE_WORDS; i++)
                    way_words[s][w][i] = '0;
            end
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_access();
        test_fifo_replacement();
        test_random_traffic(250);
        test_set_thrash(150);
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic(200);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("set_assoc_cache_fifo: match");
        else
            $display("set_assoc_cache_fifo: mismatch");
        $finish;
    end

endmodule
